// File: design/rsiw_pkg.sv
// ----------------------------------------------------------------------------
// rsiw_pkg
// Shared widths, constants and types for the RGB simplex interpolation
// weight pipeline.
// ----------------------------------------------------------------------------
package rsiw_pkg;

    // input color components, signed Q11.12
    localparam int IN_W      = 24;
    // magnitude of a clamped (non-negative) component
    localparam int MAG_W     = IN_W - 1;
    // sum of three clamped components
    localparam int SUM_W     = MAG_W + 2;

    // result fields
    localparam int CNT_W     = 2;
    localparam int IDX_W     = 12;
    localparam int WGT_W     = 17;
    localparam int FRAC_W    = 16;

    localparam int DEPTH_DEF = 24;

    // entry counts carried by a result beat
    localparam logic [CNT_W-1:0] CNT_NONE  = CNT_W'(0);
    localparam logic [CNT_W-1:0] CNT_POINT = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TRI   = CNT_W'(3);

    // weight of one in Q1.16
    localparam logic [WGT_W-1:0] WGT_ONE = {1'b1, {FRAC_W{1'b0}}};

    // side band that travels with each beat through the divider
    typedef struct packed {
        logic valid;
        logic zero;
    } rsiw_tag_t;

endpackage

// File: design/rsiw_div_pipe.sv
// ----------------------------------------------------------------------------
// rsiw_div_pipe
// Three-lane restoring divider, one quotient bit per register stage. Each
// lane computes floor(prod * 65536 / sum) for a shared divisor.
// ----------------------------------------------------------------------------
module rsiw_div_pipe
    import rsiw_pkg::*;
#(
    parameter int  DEPTH = DEPTH_DEF,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int QW    = FRAC_W + CW,
    localparam int PW    = MAG_W + CW
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  rsiw_tag_t              tag_in,
    input  logic [SUM_W-1:0]       sum_in,
    input  logic [2:0][PW-1:0]     prod_in,
    output rsiw_tag_t              tag_out,
    output logic [2:0][QW-1:0]     quo_out
);

    // partial remainder on top, dividend bits shifting out / quotient in below
    localparam int WW = SUM_W + QW;

    logic [QW-1:0]             vld_reg;
    logic [QW-1:0]             zero_reg;
    logic [SUM_W-1:0]          div_reg  [QW];
    logic [2:0][WW-1:0]        work_reg [QW];

    logic [QW:0]               stg_vld;
    logic [QW:0]               stg_zero;
    logic [SUM_W-1:0]          stg_div  [QW+1];
    logic [2:0][WW-1:0]        stg_work [QW+1];

    // load the stage-0 view: upper dividend bits are already below the divisor
    assign stg_vld[0]  = tag_in.valid;
    assign stg_zero[0] = tag_in.zero;
    assign stg_div[0]  = sum_in;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            stg_work[0][l] = {SUM_W'(prod_in[l][PW-1:CW]), prod_in[l][CW-1:0],
                              {FRAC_W{1'b0}}};
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [2:0][SUM_W:0]   trial;
        logic [2:0][SUM_W:0]   diff;
        logic [2:0]            ge;
        logic [2:0][WW-1:0]    work_next;

        // trial subtract, keep the remainder, shift in one quotient bit
        always_comb begin
            for (int l = 0; l < 3; l++) begin
                trial[l] = stg_work[k][l][WW-1:QW-1];
                diff[l]  = trial[l] - {1'b0, stg_div[k]};
                ge[l]    = (trial[l] >= {1'b0, stg_div[k]});
                work_next[l] = {(ge[l] ? diff[l][SUM_W-1:0] : trial[l][SUM_W-1:0]),
                                stg_work[k][l][QW-2:0], ge[l]};
            end
        end

        // advance valid bit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= stg_vld[k];
            end
        end

        // advance payload
        always_ff @(posedge aclk) begin
            if (adv) begin
                zero_reg[k] <= stg_zero[k];
                div_reg[k]  <= stg_div[k];
                work_reg[k] <= work_next;
            end
        end

        assign stg_vld[k+1]  = vld_reg[k];
        assign stg_zero[k+1] = zero_reg[k];
        assign stg_div[k+1]  = div_reg[k];
        assign stg_work[k+1] = work_reg[k];
    end

    assign tag_out.valid = stg_vld[QW];
    assign tag_out.zero  = stg_zero[QW];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            quo_out[l] = stg_work[QW][l][QW-1:0];
        end
    end

endmodule

// File: design/rgb_simplex_interpolation_weights.sv
// ----------------------------------------------------------------------------
// rgb_simplex_interpolation_weights
// Maps one signed Q11.12 RGB color per beat onto the triangular color
// lattice of side DEPTH and returns up to three table entries with Q1.16
// weights. The block takes one color every cycle while the output is
// not stalled, and returns one result beat per color, in order. Most
// of the pipeline is the restoring divider, which resolves one quotient
// bit per register stage for all three components at once.
// Back-pressure on the result channel stalls the whole pipeline together.
// ----------------------------------------------------------------------------
module rgb_simplex_interpolation_weights
    import rsiw_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_red,
    input  logic signed [IN_W-1:0]  s_green,
    input  logic signed [IN_W-1:0]  s_blue,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CNT_W-1:0]        m_entry_count,
    output logic [IDX_W-1:0]        m_first_index,
    output logic [WGT_W-1:0]        m_first_weight,
    output logic [IDX_W-1:0]        m_second_index,
    output logic [WGT_W-1:0]        m_second_weight,
    output logic [IDX_W-1:0]        m_third_index,
    output logic [WGT_W-1:0]        m_third_weight
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int QW   = FRAC_W + CW;
    localparam int PW   = MAG_W + CW;
    localparam int BASE = 2 * DEPTH + 3;
    localparam int BW   = $clog2(BASE + 1);
    localparam int RW0  = BW + CW + 1;
    localparam int RW   = (RW0 > IDX_W + 1) ? RW0 : IDX_W + 1;
    localparam int SW   = CW + 2;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_POINT,
        KIND_LOWER,
        KIND_UPPER
    } kind_t;

    logic adv;

    // whole pipeline moves when the output register is free or drained
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- stage 0: clamp, sum, scale by DEPTH ----------------
    logic [2:0][MAG_W-1:0]  mag;
    logic [SUM_W-1:0]       sum;

    logic                   s0_vld_reg;
    logic                   s0_zero_reg;
    logic [SUM_W-1:0]       s0_sum_reg;
    logic [2:0][PW-1:0]     s0_prod_reg;

    // drop negative components to zero
    always_comb begin
        mag[0] = s_red[IN_W-1]   ? '0 : s_red[MAG_W-1:0];
        mag[1] = s_green[IN_W-1] ? '0 : s_green[MAG_W-1:0];
        mag[2] = s_blue[IN_W-1]  ? '0 : s_blue[MAG_W-1:0];
        sum    = SUM_W'(mag[0]) + SUM_W'(mag[1]) + SUM_W'(mag[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (adv) begin
            s0_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_zero_reg <= (sum == '0);
            s0_sum_reg  <= sum;
            for (int l = 0; l < 3; l++) begin
                s0_prod_reg[l] <= PW'(mag[l]) * PW'(DEPTH);
            end
        end
    end

    // ---------------- divider stages ----------------
    rsiw_tag_t              div_tag_in;
    rsiw_tag_t              div_tag_out;
    logic [2:0][QW-1:0]     quo;

    assign div_tag_in.valid = s0_vld_reg;
    assign div_tag_in.zero  = s0_zero_reg;

    rsiw_div_pipe #(
        .DEPTH   (DEPTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .tag_in  (div_tag_in),
        .sum_in  (s0_sum_reg),
        .prod_in (s0_prod_reg),
        .tag_out (div_tag_out),
        .quo_out (quo)
    );

    // ---------------- post stage 1: classify, row offsets ----------------
    logic [CW-1:0]          ri;
    logic [CW-1:0]          gi;
    logic [CW-1:0]          bi;
    logic [SW-1:0]          isum;
    logic [BW-1:0]          diff0;
    logic [BW-1:0]          diff1;
    logic [RW-1:0]          prod0;
    logic [RW-1:0]          prod1;
    kind_t                  kind;

    logic                   p1_vld_reg;
    kind_t                  p1_kind_reg;
    logic [IDX_W-1:0]       p1_row0_reg;
    logic [IDX_W-1:0]       p1_row1_reg;
    logic [CW-1:0]          p1_gi_reg;
    logic [2:0][FRAC_W-1:0] p1_frac_reg;

    always_comb begin
        ri    = quo[0][QW-1:FRAC_W];
        gi    = quo[1][QW-1:FRAC_W];
        bi    = quo[2][QW-1:FRAC_W];
        isum  = SW'(ri) + SW'(gi) + SW'(bi);

        // row offset (BASE - r) * r / 2 for rows ri and ri + 1
        diff0 = BW'(BASE) - BW'(ri);
        diff1 = BW'(BASE) - BW'(ri) - BW'(1);
        prod0 = RW'(diff0) * RW'(ri);
        prod1 = RW'(diff1) * (RW'(ri) + RW'(1));

        if (div_tag_out.zero) begin
            kind = KIND_NONE;
        end else if (isum == SW'(DEPTH)) begin
            kind = KIND_POINT;
        end else if (isum + SW'(1) == SW'(DEPTH)) begin
            kind = KIND_LOWER;
        end else if (isum + SW'(2) == SW'(DEPTH)) begin
            kind = KIND_UPPER;
        end else begin
            kind = KIND_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (adv) begin
            p1_vld_reg <= div_tag_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_kind_reg <= kind;
            p1_row0_reg <= prod0[IDX_W:1];
            p1_row1_reg <= prod1[IDX_W:1];
            p1_gi_reg   <= gi;
            for (int l = 0; l < 3; l++) begin
                p1_frac_reg[l] <= quo[l][FRAC_W-1:0];
            end
        end
    end

    // ---------------- post stage 2: vertex indexes and weights ----------------
    logic [IDX_W-1:0]       idx_00;
    logic [IDX_W-1:0]       idx_01;
    logic [IDX_W-1:0]       idx_10;
    logic [IDX_W-1:0]       idx_11;
    logic [2:0][WGT_W-1:0]  wgt_lo;
    logic [2:0][WGT_W-1:0]  wgt_hi;

    logic [CNT_W-1:0]       cnt_next;
    logic [2:0][IDX_W-1:0]  idx_next;
    logic [2:0][WGT_W-1:0]  wgt_next;

    logic                   m_valid_reg;
    logic [CNT_W-1:0]       m_cnt_reg;
    logic [2:0][IDX_W-1:0]  m_idx_reg;
    logic [2:0][WGT_W-1:0]  m_wgt_reg;

    always_comb begin
        // idx_rc: row ri + r, column gi + c
        idx_00 = p1_row0_reg + IDX_W'(p1_gi_reg);
        idx_01 = idx_00 + IDX_W'(1);
        idx_10 = p1_row1_reg + IDX_W'(p1_gi_reg);
        idx_11 = idx_10 + IDX_W'(1);

        for (int l = 0; l < 3; l++) begin
            wgt_lo[l] = WGT_W'(p1_frac_reg[l]);
            wgt_hi[l] = WGT_ONE - WGT_W'(p1_frac_reg[l]);
        end

        cnt_next = CNT_NONE;
        idx_next = '0;
        wgt_next = '0;
        case (p1_kind_reg)
            KIND_POINT: begin
                cnt_next    = CNT_POINT;
                idx_next[0] = idx_00;
                wgt_next[0] = WGT_ONE;
            end
            KIND_LOWER: begin
                cnt_next    = CNT_TRI;
                idx_next[0] = idx_10;
                idx_next[1] = idx_01;
                idx_next[2] = idx_00;
                wgt_next    = wgt_lo;
            end
            KIND_UPPER: begin
                cnt_next    = CNT_TRI;
                idx_next[0] = idx_01;
                idx_next[1] = idx_10;
                idx_next[2] = idx_11;
                wgt_next    = wgt_hi;
            end
            default: begin
                cnt_next = CNT_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_cnt_reg <= cnt_next;
            m_idx_reg <= idx_next;
            m_wgt_reg <= wgt_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_entry_count   = m_cnt_reg;
    assign m_first_index   = m_idx_reg[0];
    assign m_first_weight  = m_wgt_reg[0];
    assign m_second_index  = m_idx_reg[1];
    assign m_second_weight = m_wgt_reg[1];
    assign m_third_index   = m_idx_reg[2];
    assign m_third_weight  = m_wgt_reg[2];

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_simplex_interpolation_weights. Drives signed
// RGB colors through the valid/ready input channel in random bursts and
// computes the expected lattice entries and Q1.16 weights for every
// accepted beat. Result beats are checked in order against a scoreboard
// while the result channel stalls on its own changing pattern.
// ----------------------------------------------------------------------------
import rsiw_pkg::*;

localparam int LATTICE_DEPTH = DEPTH_DEF;

typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic [IDX_W-1:0] first_index;
    logic [WGT_W-1:0] first_weight;
    logic [IDX_W-1:0] second_index;
    logic [WGT_W-1:0] second_weight;
    logic [IDX_W-1:0] third_index;
    logic [WGT_W-1:0] third_weight;
} weight_beat_t;

class weight_scoreboard;
    weight_beat_t pending[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  n_empty;
    int unsigned  n_point;
    int unsigned  n_lower;
    int unsigned  n_upper;

    // triangular table entry of lattice row and column
    function logic [IDX_W-1:0] table_entry(longint unsigned row, longint unsigned col);
        longint unsigned base;
        longint unsigned row_start;
        base      = 2 * LATTICE_DEPTH + 3;
        row_start = (row <= base) ? (base - row) * row / 2 : 0;
        return IDX_W'(row_start + col);
    endfunction

    // clamp negatives to zero, keep the magnitude otherwise
    function longint unsigned clamp_comp(logic signed [IN_W-1:0] c);
        if (c[IN_W-1])
            return 0;
        return longint'(c[MAG_W-1:0]);
    endfunction

    // expected result beat for one color
    function weight_beat_t lattice_weights(logic signed [IN_W-1:0] red,
                                           logic signed [IN_W-1:0] green,
                                           logic signed [IN_W-1:0] blue);
        weight_beat_t    res;
        longint unsigned r, g, b, total;
        longint unsigned qr, qg, qb, ri, gi, bi, fr, fg, fb, isum;
        res   = '0;
        r     = clamp_comp(red);
        g     = clamp_comp(green);
        b     = clamp_comp(blue);
        total = r + g + b;
        if (total == 0) begin
            res.entry_count = CNT_NONE;
            return res;
        end
        qr   = r * LATTICE_DEPTH * 65536 / total;
        qg   = g * LATTICE_DEPTH * 65536 / total;
        qb   = b * LATTICE_DEPTH * 65536 / total;
        ri   = qr >> FRAC_W;
        gi   = qg >> FRAC_W;
        bi   = qb >> FRAC_W;
        fr   = qr & 16'hFFFF;
        fg   = qg & 16'hFFFF;
        fb   = qb & 16'hFFFF;
        isum = ri + gi + bi;
        if (isum == LATTICE_DEPTH) begin
            res.entry_count  = CNT_POINT;
            res.first_index  = table_entry(ri, gi);
            res.first_weight = WGT_ONE;
        end else if (isum + 1 == LATTICE_DEPTH) begin
            // lower triangle: weights are the fractions
            res.entry_count   = CNT_TRI;
            res.first_index   = table_entry(ri + 1, gi);
            res.first_weight  = WGT_W'(fr);
            res.second_index  = table_entry(ri, gi + 1);
            res.second_weight = WGT_W'(fg);
            res.third_index   = table_entry(ri, gi);
            res.third_weight  = WGT_W'(fb);
        end else if (isum + 2 == LATTICE_DEPTH) begin
            // upper triangle: weights are one minus the fractions
            res.entry_count   = CNT_TRI;
            res.first_index   = table_entry(ri, gi + 1);
            res.first_weight  = WGT_W'(65536 - fr);
            res.second_index  = table_entry(ri + 1, gi);
            res.second_weight = WGT_W'(65536 - fg);
            res.third_index   = table_entry(ri + 1, gi + 1);
            res.third_weight  = WGT_W'(65536 - fb);
        end
        return res;
    endfunction

    function void note_color(logic signed [IN_W-1:0] red,
                             logic signed [IN_W-1:0] green,
                             logic signed [IN_W-1:0] blue);
        pending.insert(pending.size(), lattice_weights(red, green, blue));
    endfunction

    function void report_beat(string tag, weight_beat_t w);
        $display("  %s: count %0d  idx %0d/%0d/%0d  wgt %0d/%0d/%0d", tag, w.entry_count,
                 w.first_index, w.second_index, w.third_index,
                 w.first_weight, w.second_weight, w.third_weight);
    endfunction

    function void check_beat(weight_beat_t got);
        weight_beat_t want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("ERROR: result beat with nothing outstanding");
                report_beat("actual", got);
            end
            return;
        end
        want = pending.pop_front();
        checked++;
        if (want.entry_count == CNT_NONE)
            n_empty++;
        else if (want.entry_count == CNT_POINT)
            n_point++;
        else if (want.first_weight + want.second_weight + want.third_weight > 65536)
            n_upper++;
        else
            n_lower++;
        if (got.entry_count   !== want.entry_count   ||
            got.first_index   !== want.first_index   ||
            got.first_weight  !== want.first_weight  ||
            got.second_index  !== want.second_index  ||
            got.second_weight !== want.second_weight ||
            got.third_index   !== want.third_index   ||
            got.third_weight  !== want.third_weight) begin
            errors++;
            if (errors <= 10) begin
                $display("ERROR: mismatch on result beat %0d", checked);
                report_beat("expected", want);
                report_beat("actual  ", got);
            end
        end
    endfunction
endclass

module tb;

    localparam int          NUM_RANDOM  = 1930;
    localparam int          DRAIN_WAIT  = 60;
    localparam int unsigned CYCLE_LIMIT = 600000;

    localparam logic signed [IN_W-1:0] COMP_MAX = 24'sh7FFFFF;
    localparam logic signed [IN_W-1:0] COMP_MIN = 24'sh800000;

    logic                   aclk    = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [IN_W-1:0] s_red   = '0;
    logic signed [IN_W-1:0] s_green = '0;
    logic signed [IN_W-1:0] s_blue  = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    weight_beat_t           m_beat;

    weight_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int unsigned colors_sent = 0;
    int          burst_left  = 0;

    rgb_simplex_interpolation_weights #(
        .DEPTH(LATTICE_DEPTH)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_entry_count  (m_beat.entry_count),
        .m_first_index  (m_beat.first_index),
        .m_first_weight (m_beat.first_weight),
        .m_second_index (m_beat.second_index),
        .m_second_weight(m_beat.second_weight),
        .m_third_index  (m_beat.third_index),
        .m_third_weight (m_beat.third_weight)
    );

    // clock, 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // abort on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending.size());
            $display("FAIL");
            $finish;
        end
    end

    // result side: stall on a pattern whose mode is redrawn at random
    int unsigned stall_mode  = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_phase = 0;
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(40, 300);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_phase % 7 > 2);
        endcase
    end

    // check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_beat(m_beat);
    end

    // send one color, opening a new burst after a random gap when the last one ends
    task automatic push_color(logic signed [IN_W-1:0] red,
                              logic signed [IN_W-1:0] green,
                              logic signed [IN_W-1:0] blue);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 60);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                s_red   <= IN_W'($urandom());
                s_green <= IN_W'($urandom());
                s_blue  <= IN_W'($urandom());
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_red   <= red;
        s_green <= green;
        s_blue  <= blue;
        do @(posedge aclk); while (!s_ready);
        sb.note_color(red, green, blue);
        colors_sent++;
    endtask

    // random component, biased toward the shapes that reach every branch
    task automatic random_color(output logic signed [IN_W-1:0] red,
                                output logic signed [IN_W-1:0] green,
                                output logic signed [IN_W-1:0] blue);
        int unsigned pick;
        int unsigned a, b, k;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            // full range, both signs
            red   = IN_W'($urandom());
            green = IN_W'($urandom());
            blue  = IN_W'($urandom());
        end else if (pick < 7) begin
            // small magnitudes: frequent lattice points and both triangles
            red   = IN_W'($urandom_range(0, 40));
            green = IN_W'($urandom_range(0, 40));
            blue  = IN_W'($urandom_range(0, 40));
        end else if (pick < 9) begin
            // scaled lattice point, sometimes nudged off it
            a     = $urandom_range(0, LATTICE_DEPTH);
            b     = $urandom_range(0, LATTICE_DEPTH - a);
            k     = $urandom_range(1, 8388607 / LATTICE_DEPTH);
            red   = IN_W'(a * k);
            green = IN_W'(b * k);
            blue  = IN_W'((LATTICE_DEPTH - a - b) * k);
            if ($urandom_range(0, 1)) begin
                red = IN_W'(red + $urandom_range(0, 1));
                if (blue > 0)
                    blue = IN_W'(blue - $urandom_range(0, 1));
            end
        end else begin
            // positive colors with one or two negative components
            red   = IN_W'($urandom_range(0, 8388607));
            green = $urandom_range(0, 1) ? IN_W'(-$urandom_range(1, 8388608))
                                         : IN_W'($urandom_range(0, 8388607));
            blue  = IN_W'(-$urandom_range(1, 8388608));
        end
    endtask

    logic signed [IN_W-1:0] rnd_red, rnd_green, rnd_blue;

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero and negative sums, extremes, single components,
        // exact points, lower and upper triangles
        push_color(24'sd0, 24'sd0, 24'sd0);
        push_color(-24'sd1, -24'sd1, -24'sd1);
        push_color(COMP_MIN, COMP_MIN, COMP_MIN);
        push_color(COMP_MAX, COMP_MAX, COMP_MAX);
        push_color(COMP_MAX, 24'sd0, 24'sd0);
        push_color(24'sd0, COMP_MAX, 24'sd0);
        push_color(24'sd0, 24'sd0, COMP_MAX);
        push_color(COMP_MAX, COMP_MIN, 24'sd0);
        push_color(24'sd1, 24'sd0, COMP_MIN);
        push_color(24'sd1, 24'sd1, 24'sd1);
        push_color(24'sd1, 24'sd1, 24'sd0);
        push_color(24'sd1, 24'sd1, 24'sd5);
        push_color(24'sd2, 24'sd2, 24'sd3);
        push_color(24'sd2, 24'sd3, 24'sd2);
        push_color(24'sd3, 24'sd5, 24'sd7);
        push_color(24'sd7, 24'sd11, 24'sd13);
        push_color(24'sd1, 24'sd2, COMP_MAX);
        push_color(COMP_MAX, COMP_MAX, 24'sd1);
        push_color(COMP_MIN, 24'sd5, 24'sd7);
        push_color(24'sh400000, 24'sh200000, 24'sd1);
        push_color(24'sh555555, 24'sh2AAAAA, 24'sh0F0F0F);

        repeat (NUM_RANDOM) begin
            random_color(rnd_red, rnd_green, rnd_blue);
            push_color(rnd_red, rnd_green, rnd_blue);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("sent %0d colors, checked %0d results in %0d cycles",
                 colors_sent, sb.checked, cycle_count);
        $display("empty %0d, lattice points %0d, lower %0d, upper %0d, errors %0d",
                 sb.n_empty, sb.n_point, sb.n_lower, sb.n_upper, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
